// ===== hdl/fraction_reducer_macros.svh =====
// Assertion macros used by the fraction reducer checker.
`ifndef FRACTION_REDUCER_MACROS_SVH
`define FRACTION_REDUCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define FR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define FR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fr_pkg.sv =====
// Types, control word layout and microcode table of the fraction reducer.
`default_nettype none
package fr_pkg;

  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT_IN,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_GCD_SWAP,
    OP_SAVE_RN,
    OP_EMIT_RES,
    OP_EMIT_ERR
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_DEN_ZERO,
    COND_NUM_ZERO,
    COND_Y_ZERO,
    COND_EMIT_ZERO
  } cond_t;

  // dividend / divisor selection for the shared divider
  typedef enum logic [1:0] {
    SRC_X_BY_Y,
    SRC_N_BY_X,
    SRC_D_BY_X
  } src_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    src_t            src;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_GCD_TEST = 4'd3;
  localparam logic [PC_W-1:0] PC_GCD_DONE = 4'd7;
  localparam logic [PC_W-1:0] PC_ERR      = 4'd13;
  localparam logic [PC_W-1:0] PC_ZERO     = 4'd14;

  // Zero numerator reuses OP_EMIT_ERR's slot type: OP_EMIT_ERR with
  // COND_EMIT_ZERO marks the zero-over-one result.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{op: OP_NOP, cond: COND_ALWAYS, src: SRC_X_BY_Y, target: PC_IDLE};
    case (pc)
      4'd0:  c = '{op: OP_WAIT_IN,   cond: COND_NONE,      src: SRC_X_BY_Y, target: PC_IDLE};
      4'd1:  c = '{op: OP_NOP,       cond: COND_DEN_ZERO,  src: SRC_X_BY_Y, target: PC_ERR};
      4'd2:  c = '{op: OP_NOP,       cond: COND_NUM_ZERO,  src: SRC_X_BY_Y, target: PC_ZERO};
      4'd3:  c = '{op: OP_NOP,       cond: COND_Y_ZERO,    src: SRC_X_BY_Y, target: PC_GCD_DONE};
      4'd4:  c = '{op: OP_DIV_START, cond: COND_NONE,      src: SRC_X_BY_Y, target: PC_IDLE};
      4'd5:  c = '{op: OP_DIV_STEP,  cond: COND_NONE,      src: SRC_X_BY_Y, target: PC_IDLE};
      4'd6:  c = '{op: OP_GCD_SWAP,  cond: COND_ALWAYS,    src: SRC_X_BY_Y, target: PC_GCD_TEST};
      4'd7:  c = '{op: OP_DIV_START, cond: COND_NONE,      src: SRC_N_BY_X, target: PC_IDLE};
      4'd8:  c = '{op: OP_DIV_STEP,  cond: COND_NONE,      src: SRC_N_BY_X, target: PC_IDLE};
      4'd9:  c = '{op: OP_SAVE_RN,   cond: COND_NONE,      src: SRC_N_BY_X, target: PC_IDLE};
      4'd10: c = '{op: OP_DIV_START, cond: COND_NONE,      src: SRC_D_BY_X, target: PC_IDLE};
      4'd11: c = '{op: OP_DIV_STEP,  cond: COND_NONE,      src: SRC_D_BY_X, target: PC_IDLE};
      4'd12: c = '{op: OP_EMIT_RES,  cond: COND_ALWAYS,    src: SRC_D_BY_X, target: PC_IDLE};
      4'd13: c = '{op: OP_EMIT_ERR,  cond: COND_ALWAYS,    src: SRC_X_BY_Y, target: PC_IDLE};
      4'd14: c = '{op: OP_EMIT_ERR,  cond: COND_EMIT_ZERO, src: SRC_X_BY_Y, target: PC_IDLE};
      default: c = '{op: OP_NOP,     cond: COND_ALWAYS,    src: SRC_X_BY_Y, target: PC_IDLE};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fr_ifs.sv =====
// Valid/ready channel interfaces for operands and results.
`default_nettype none
interface fr_operand_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] numerator;
  logic signed [W-1:0] denominator;
  modport source (output valid, numerator, denominator, input ready);
  modport sink   (input valid, numerator, denominator, output ready);
endinterface

interface fr_result_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] reduced_numerator;
  logic signed [W-1:0] reduced_denominator;
  logic                is_whole;
  logic                divide_error;
  modport source (output valid, reduced_numerator, reduced_denominator, is_whole,
                  divide_error, input ready);
  modport sink   (input valid, reduced_numerator, reduced_denominator, is_whole,
                  divide_error, output ready);
endinterface
`default_nettype wire

// ===== hdl/fraction_reducer.sv =====
// Euclid remainder steps: at most 45 at 32 bits.
// Each remainder and each final quotient comes from one restoring divider, one bit per cycle.
// Zero denominator branches straight to the error result; zero numerator to the zero-over-one result.
// One item at a time; the next operand transfer is taken while a result waits.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops result valid.
`default_nettype none
module fraction_reducer #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire          clk,
  input  wire          rst,
  fr_operand_if.sink   operands,
  fr_result_if.source  result
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [fr_pkg::PC_W-1:0] pc, pc_next;
  fr_pkg::ctrl_t           ctrl;

  logic [W-1:0]  nmag, dmag, x, y, rn;
  logic          nneg, dneg;
  logic [W-1:0]  quo, rem, div_b;
  logic [CW-1:0] cnt;

  logic [W-1:0]  in_n, in_d, in_nmag, in_dmag;
  logic [W:0]    trial_sh, trial;
  logic          accept, out_busy, emitting, hold, take;

  logic                out_valid, out_whole, out_err;
  logic [W-1:0]        out_n, out_d;

  assign ctrl = fr_pkg::ucode(pc);

  assign in_n    = operands.numerator;
  assign in_d    = operands.denominator;
  assign in_nmag = in_n[W-1] ? (~in_n + W'(1)) : in_n;
  assign in_dmag = in_d[W-1] ? (~in_d + W'(1)) : in_d;

  assign operands.ready = (ctrl.op == fr_pkg::OP_WAIT_IN);
  assign accept         = operands.valid && operands.ready;

  assign out_busy = out_valid && !result.ready;
  assign emitting = (ctrl.op == fr_pkg::OP_EMIT_RES || ctrl.op == fr_pkg::OP_EMIT_ERR)
                    && !out_busy;

  // restoring divider step: shift in next dividend bit, try subtract
  assign trial_sh = {rem, quo[W-1]};
  assign trial    = trial_sh - {1'b0, div_b};

  always_comb begin
    hold = 1'b0;
    case (ctrl.op)
      fr_pkg::OP_WAIT_IN:  hold = !accept;
      fr_pkg::OP_DIV_STEP: hold = (cnt != CW'(1));
      fr_pkg::OP_EMIT_RES,
      fr_pkg::OP_EMIT_ERR: hold = out_busy;
      default:             hold = 1'b0;
    endcase
    case (ctrl.cond)
      fr_pkg::COND_ALWAYS,
      fr_pkg::COND_EMIT_ZERO: take = 1'b1;
      fr_pkg::COND_DEN_ZERO:  take = (dmag == '0);
      fr_pkg::COND_NUM_ZERO:  take = (nmag == '0);
      fr_pkg::COND_Y_ZERO:    take = (y == '0);
      default:                take = 1'b0;
    endcase
    if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + fr_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= fr_pkg::PC_IDLE;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (emitting) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (ctrl.op)
      fr_pkg::OP_WAIT_IN: begin
        if (accept) begin
          nmag <= in_nmag;
          dmag <= in_dmag;
          nneg <= in_n[W-1];
          dneg <= in_d[W-1];
          x    <= in_nmag;
          y    <= in_dmag;
        end
      end
      fr_pkg::OP_DIV_START: begin
        rem <= '0;
        cnt <= CW'(W);
        case (ctrl.src)
          fr_pkg::SRC_N_BY_X: begin
            quo   <= nmag;
            div_b <= x;
          end
          fr_pkg::SRC_D_BY_X: begin
            quo   <= dmag;
            div_b <= x;
          end
          default: begin
            quo   <= x;
            div_b <= y;
          end
        endcase
      end
      fr_pkg::OP_DIV_STEP: begin
        cnt <= cnt - CW'(1);
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= trial_sh[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
      end
      fr_pkg::OP_GCD_SWAP: begin
        x <= y;
        y <= rem;
      end
      fr_pkg::OP_SAVE_RN: begin
        rn <= quo;
      end
      default: begin
      end
    endcase

    if (emitting) begin
      if (ctrl.op == fr_pkg::OP_EMIT_RES) begin
        out_n     <= nneg ? (~rn + W'(1)) : rn;
        out_d     <= dneg ? (~quo + W'(1)) : quo;
        out_whole <= !dneg && (quo == W'(1));
        out_err   <= 1'b0;
      end else if (ctrl.cond == fr_pkg::COND_EMIT_ZERO) begin
        out_n     <= '0;
        out_d     <= W'(1);
        out_whole <= 1'b1;
        out_err   <= 1'b0;
      end else begin
        out_n     <= '0;
        out_d     <= '0;
        out_whole <= 1'b0;
        out_err   <= 1'b1;
      end
    end
  end

  assign result.valid               = out_valid;
  assign result.reduced_numerator   = out_n;
  assign result.reduced_denominator = out_d;
  assign result.is_whole            = out_whole;
  assign result.divide_error        = out_err;

endmodule
`default_nettype wire

// ===== hdl/fr_checker.sv =====
// Port-level checks of the fraction reducer result channel, bound to the top level.
`default_nettype none
`include "fraction_reducer_macros.svh"
module fr_checker #(
  parameter int W = 32
) (
  input wire                clk,
  input wire                rst,
  input wire                res_valid,
  input wire                res_ready,
  input wire signed [W-1:0] res_num,
  input wire signed [W-1:0] res_den,
  input wire                res_whole,
  input wire                res_err
);

  `FR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_num) && $stable(res_den), "stalled result changed")
  `FR_ASSERT_NOW(a_err_zero, res_valid && res_err, res_num == '0 && res_den == '0 && !res_whole, "error result not cleared")
  `FR_ASSERT_NOW(a_whole_one, res_valid && res_whole, res_den == W'(1) && !res_err, "whole result without denominator one")
  `FR_ASSERT_NOW(a_den_nonzero, res_valid && !res_err, res_den != '0, "zero denominator without error")

endmodule

bind fraction_reducer fr_checker #(.W(VALUE_WIDTH)) u_fr_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_num   (result.reduced_numerator),
  .res_den   (result.reduced_denominator),
  .res_whole (result.is_whole),
  .res_err   (result.divide_error)
);
`default_nettype wire

// ===== tb/fraction_reducer_tb.sv =====
// Self-checking testbench for fraction_reducer: directed corner cases, then randomized fractions.
`default_nettype none
module fraction_reducer_tb;

  localparam int W = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [W-1:0] MOST_POS = 32'h7fff_ffff;

  typedef struct packed {
    logic signed [W-1:0] reduced_numerator;
    logic signed [W-1:0] reduced_denominator;
    logic                is_whole;
    logic                divide_error;
  } reduced_fraction_t;

  logic clk;
  logic rst;

  fr_operand_if #(.W(W)) operands_ch ();
  fr_result_if  #(.W(W)) result_ch ();

  fraction_reducer #(.VALUE_WIDTH(W)) uut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_ch),
    .result   (result_ch)
  );

  reduced_fraction_t pending_reductions[$];
  int failures = 0;
  int fractions_sent = 0;
  int results_checked = 0;
  int divide_errors_seen = 0;
  int zero_numerators_seen = 0;
  int whole_results_seen = 0;
  int negative_unit_dens_seen = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  logic [15:0] stall_pattern = 16'hffff;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Lowest terms by Euclid on the magnitudes; each part keeps its sign (zero numerator: 0/1).
  function automatic reduced_fraction_t reduce_fraction(input logic [W-1:0] num,
                                                        input logic [W-1:0] den);
    reduced_fraction_t res;
    logic [W-1:0] nmag, dmag, x, y, r, qn, qd;
    res = '0;
    nmag = num[W-1] ? -num : num;
    dmag = den[W-1] ? -den : den;
    if (dmag == '0) begin
      res.divide_error = 1'b1;
    end else if (nmag == '0) begin
      res.reduced_denominator = 1;
      res.is_whole = 1'b1;
    end else begin
      x = nmag;
      y = dmag;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      qn = nmag / x;
      qd = dmag / x;
      res.reduced_numerator = num[W-1] ? -qn : qn;
      res.reduced_denominator = den[W-1] ? -qd : qd;
      res.is_whole = (res.reduced_denominator == 1);
    end
    return res;
  endfunction

  // Predict on every operand transfer.
  always @(posedge clk) begin
    reduced_fraction_t want;
    if (!rst && operands_ch.valid && operands_ch.ready) begin
      want = reduce_fraction(operands_ch.numerator, operands_ch.denominator);
      pending_reductions.push_back(want);
      fractions_sent++;
      if (want.divide_error) divide_errors_seen++;
      else if (want.reduced_numerator == 0) zero_numerators_seen++;
      if (want.is_whole) whole_results_seen++;
      if (want.reduced_denominator == -1) negative_unit_dens_seen++;
    end
  end

  always @(posedge clk) begin
    reduced_fraction_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_reductions.size() == 0) begin
        $error("result transfer with no fraction pending");
        failures++;
      end else begin
        want = pending_reductions.pop_front();
        results_checked++;
        if (result_ch.reduced_numerator !== want.reduced_numerator) begin
          $error("reduced_numerator: expected %0d, got %0d",
                 want.reduced_numerator, $signed(result_ch.reduced_numerator));
          failures++;
        end
        if (result_ch.reduced_denominator !== want.reduced_denominator) begin
          $error("reduced_denominator: expected %0d, got %0d",
                 want.reduced_denominator, $signed(result_ch.reduced_denominator));
          failures++;
        end
        if (result_ch.is_whole !== want.is_whole) begin
          $error("is_whole: expected %0b, got %0b", want.is_whole, result_ch.is_whole);
          failures++;
        end
        if (result_ch.divide_error !== want.divide_error) begin
          $error("divide_error: expected %0b, got %0b",
                 want.divide_error, result_ch.divide_error);
          failures++;
        end
      end
    end
  end

  // Receiver: rotate a stall pattern, reload it now and then.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= stall_pattern[0];
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern <= 16'hffff;
          1: stall_pattern <= 16'($urandom());
          2: stall_pattern <= 16'($urandom() & $urandom()) | 16'h0001;
          default: stall_pattern <= 16'($urandom() | $urandom());
        endcase
        stall_left <= $urandom_range(16, 400);
      end else begin
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        stall_left <= stall_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (operands_ch.valid && operands_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("fraction_reducer_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_fraction(input logic [W-1:0] num, input logic [W-1:0] den);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1800) : $urandom_range(0, 12);
      if (gap > 0) begin
        operands_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    operands_ch.valid <= 1'b1;
    operands_ch.numerator <= num;
    operands_ch.denominator <= den;
    do @(posedge clk); while (!(operands_ch.valid && operands_ch.ready));
    burst_left--;
  endtask

  task automatic test_special_cases();
    send_fraction(0, 5);
    send_fraction(0, -7);
    send_fraction(0, MOST_NEG);
    send_fraction(5, 0);
    send_fraction(0, 0);
    send_fraction(MOST_NEG, 0);
    send_fraction(6, -3);
    send_fraction(-4, -4);
    send_fraction(MOST_NEG, 1);
    send_fraction(MOST_NEG, -1);
    send_fraction(MOST_NEG, MOST_NEG);
    send_fraction(1, MOST_NEG);
    send_fraction(MOST_NEG, 6);
    send_fraction(MOST_POS, MOST_POS);
    send_fraction(MOST_POS, 1);
    send_fraction(1, MOST_POS);
    send_fraction(MOST_NEG + 1, MOST_POS);
    send_fraction(12, 18);
    send_fraction(-12, 18);
    send_fraction(12, -18);
    send_fraction(-12, -18);
    send_fraction(10, 5);
    // consecutive Fibonacci numbers: the longest remainder chain
    send_fraction(1836311903, 1134903170);
    send_fraction(-1134903170, 1836311903);
  endtask

  task automatic test_wide_operands(input int count);
    repeat (count) send_fraction($urandom(), $urandom());
  endtask

  task automatic test_shared_factors(input int count);
    logic [W-1:0] factor, num, den;
    repeat (count) begin
      factor = $urandom_range(1, 65535);
      num = factor * $urandom_range(0, 32767);
      den = factor * $urandom_range(0, 32767);
      if ($urandom_range(0, 1)) num = -num;
      if ($urandom_range(0, 1)) den = -den;
      send_fraction(num, den);
    end
  endtask

  function automatic logic [W-1:0] pick_small_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 19))
      0: v = MOST_NEG;
      1: v = MOST_POS;
      2: v = MOST_NEG + 1;
      3: v = $urandom_range(0, 1) ? 1 : -1;
      default: begin
        v = $urandom_range(0, 40);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic test_small_operands(input int count);
    logic [W-1:0] num, den;
    repeat (count) begin
      num = pick_small_operand();
      den = pick_small_operand();
      send_fraction(num, den);
    end
  endtask

  initial begin
    rst = 1'b1;
    operands_ch.valid = 1'b0;
    operands_ch.numerator = '0;
    operands_ch.denominator = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_wide_operands(600);
    test_shared_factors(700);
    test_small_operands(550);

    operands_ch.valid <= 1'b0;
    while (pending_reductions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_reductions.size() != 0) begin
      $error("%0d results never arrived", pending_reductions.size());
      failures++;
    end
    $display("%0d fractions sent, %0d results checked, %0d mismatches",
             fractions_sent, results_checked, failures);
    $display("%0d zero denominators, %0d zero numerators, %0d whole, %0d over minus one",
             divide_errors_seen, zero_numerators_seen, whole_results_seen,
             negative_unit_dens_seen);
    if (failures == 0) begin
      $display("fraction_reducer_tb passed");
    end else begin
      $display("fraction_reducer_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
